/* hdl/nalsplit_pkg.sv */
// ----------------------------------------------------------------------------
// nalsplit_pkg
// Shared types and constants for the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package nalsplit_pkg;

    localparam int unsigned CFG_W   = 6;   // min_stream_length register width
    localparam int unsigned THR_W   = 7;   // compare width for byte count vs threshold
    localparam int unsigned WIN_N   = 4;   // look-ahead window depth

    localparam logic [CFG_W-1:0] MIN_LEN_RESET = 6'd4;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] TYPE_MASK = 8'h1F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [4:0] nal_type;
        logic       unit_first;
        logic       unit_last;
    } out_item_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_FEED,
        DP_FIN_POS,
        DP_FIN_EMIT,
        DP_CLEAR
    } dp_op_t;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_RAM,
        SRC_HELD
    } dp_src_t;

    typedef struct packed {
        dp_op_t     op;
        dp_src_t    src;
        logic [1:0] pos;        // window slot for a finish-time position
        logic       hold_load;  // capture the incoming byte for the end of a release
        logic       ram_we;
        logic       ram_re;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] fill;       // look-ahead window fill count, 0..4
        logic       out_free;   // result register can take a transfer this cycle
    } dp_sts_t;

endpackage

/* hdl/nalsplit_ram.sv */
// ----------------------------------------------------------------------------
// nalsplit_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nalsplit_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/nalsplit_dp.sv */
// ----------------------------------------------------------------------------
// nalsplit_dp
// Datapath: hold buffer, look-ahead window, start code match, pending byte
// and result register.
// ----------------------------------------------------------------------------
module nalsplit_dp
    import nalsplit_pkg::*;
#(
    parameter int unsigned HOLD_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dp_cmd_t                       cmd,
    input  logic [$clog2(HOLD_DEPTH)-1:0] ram_addr,
    input  logic [7:0]                    in_byte,
    output dp_sts_t                       sts,
    output logic                          m_valid,
    input  logic                          m_ready,
    output out_item_t                     m_data
);

    logic [7:0] ram_rdata;
    logic [7:0] held_reg;

    logic [7:0] win_reg  [WIN_N];
    logic [7:0] win_next [WIN_N];
    logic [2:0] fill_reg, fill_next;
    logic       inside_reg, inside_next;
    logic [4:0] type_reg, type_next;
    logic [2:0] skip_reg, skip_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_first_reg, pend_first_next;

    logic       emit;
    logic       emit_last;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    nalsplit_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold (
        .aclk  (aclk),
        .we    (cmd.ram_we),
        .waddr (ram_addr),
        .wdata (in_byte),
        .re    (cmd.ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic [7:0] fb;
        logic [7:0] hb;
        logic       do_handle;
        logic       testable;
        logic       m3;
        logic       m4;

        fb        = in_byte;
        hb        = BYTE_ZERO;
        do_handle = 1'b0;
        testable  = 1'b0;
        m3        = 1'b0;
        m4        = 1'b0;

        win_next        = win_reg;
        fill_next       = fill_reg;
        inside_next     = inside_reg;
        type_next       = type_reg;
        skip_next       = skip_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_first_next = pend_first_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;

        unique case (cmd.src)
            SRC_IN:   fb = in_byte;
            SRC_RAM:  fb = ram_rdata;
            SRC_HELD: fb = held_reg;
            default:  fb = in_byte;
        endcase

        unique case (cmd.op)
            DP_FEED: begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = win_reg[3];
                win_next[3] = fb;
                fill_next   = (fill_reg == 3'(WIN_N)) ? fill_reg : fill_reg + 3'd1;
                if (fill_next == 3'(WIN_N)) begin
                    do_handle = 1'b1;
                    testable  = 1'b1;
                    hb        = win_next[0];
                end
            end
            DP_FIN_POS: begin
                do_handle = 1'b1;
                hb        = win_reg[cmd.pos];
            end
            DP_FIN_EMIT: begin
                emit      = pend_valid_reg;
                emit_last = 1'b1;
            end
            DP_CLEAR, DP_NOP: begin
            end
            default: begin
            end
        endcase

        if (do_handle) begin
            m3 = testable && win_next[0] == BYTE_ZERO && win_next[1] == BYTE_ZERO
                 && win_next[2] == BYTE_ONE;
            m4 = testable && win_next[0] == BYTE_ZERO && win_next[1] == BYTE_ZERO
                 && win_next[2] == BYTE_ZERO && win_next[3] == BYTE_ONE;
            if (skip_reg != 3'd0) begin
                // Header byte of the new unit lands on the last skipped position.
                if (skip_reg == 3'd1) begin
                    inside_next     = 1'b1;
                    type_next       = 5'(hb & TYPE_MASK);
                    pend_valid_next = 1'b1;
                    pend_byte_next  = hb;
                    pend_first_next = 1'b1;
                end
                skip_next = skip_reg - 3'd1;
            end else if (m3 || m4) begin
                // Start code closes the running unit.
                emit            = pend_valid_reg;
                emit_last       = 1'b1;
                pend_valid_next = 1'b0;
                skip_next       = m3 ? 3'd3 : 3'd4;
            end else if (inside_reg) begin
                emit            = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_byte_next  = hb;
                pend_first_next = 1'b0;
            end
        end

        if (cmd.op == DP_FIN_EMIT || cmd.op == DP_CLEAR) begin
            for (int i = 0; i < WIN_N; i++) begin
                win_next[i] = BYTE_ZERO;
            end
            fill_next       = 3'd0;
            inside_next     = 1'b0;
            type_next       = 5'd0;
            skip_next       = 3'd0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WIN_N; i++) begin
                win_reg[i] <= BYTE_ZERO;
            end
            fill_reg       <= 3'd0;
            inside_reg     <= 1'b0;
            type_reg       <= 5'd0;
            skip_reg       <= 3'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            win_reg        <= win_next;
            fill_reg       <= fill_next;
            inside_reg     <= inside_next;
            type_reg       <= type_next;
            skip_reg       <= skip_next;
            pend_valid_reg <= pend_valid_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_byte_reg  <= pend_byte_next;
        pend_first_reg <= pend_first_next;
        if (cmd.hold_load) begin
            held_reg <= in_byte;
        end
        if (emit) begin
            m_data_reg.payload_byte <= pend_byte_reg;
            m_data_reg.nal_type     <= type_reg;
            m_data_reg.unit_first   <= pend_first_reg;
            m_data_reg.unit_last    <= emit_last;
        end
    end

    assign sts.fill     = fill_reg;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

/* hdl/nalsplit_ctrl.sv */
// ----------------------------------------------------------------------------
// nalsplit_ctrl
// Controller: hold phase counting, release burst sequencing and
// end-of-stream flush.
// ----------------------------------------------------------------------------
module nalsplit_ctrl
    import nalsplit_pkg::*;
#(
    parameter int unsigned HOLD_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [CFG_W-1:0]              min_len,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_final,
    input  dp_sts_t                       sts,
    output dp_cmd_t                       cmd,
    output logic [$clog2(HOLD_DEPTH)-1:0] ram_addr
);

    localparam int unsigned AW = $clog2(HOLD_DEPTH);
    localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REL_RD,
        ST_REL_FEED,
        ST_REL_LAST,
        ST_FIN,
        ST_FIN_EMIT
    } state_t;

    state_t         state_reg, state_next;
    logic           released_reg, released_next;
    logic [CW-1:0]  seen_reg, seen_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           fin_reg, fin_next;
    logic [1:0]     pos_reg, pos_next;

    logic [THR_W-1:0] thr;
    logic [THR_W-1:0] depth_c;
    logic [2:0]       fin_start;
    logic             accept;

    assign depth_c   = THR_W'(HOLD_DEPTH);
    assign thr       = (THR_W'(min_len) > depth_c) ? depth_c : THR_W'(min_len);
    assign fin_start = (sts.fill >= 3'(WIN_N)) ? 3'd1 : 3'(WIN_N) - sts.fill;
    assign s_ready   = (state_reg == ST_IDLE) && sts.out_free;
    assign accept    = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        released_next = released_reg;
        seen_next     = seen_reg;
        idx_next      = idx_reg;
        fin_next      = fin_reg;
        pos_next      = pos_reg;
        cmd           = '{op: DP_NOP, src: SRC_IN, pos: 2'd0,
                          hold_load: 1'b0, ram_we: 1'b0, ram_re: 1'b0};
        ram_addr      = seen_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (released_reg) begin
                        cmd.op = DP_FEED;
                        if (s_final) begin
                            pos_next   = 2'd1;
                            state_next = ST_FIN;
                        end
                    end else if (THR_W'(seen_reg) >= thr) begin
                        cmd.hold_load = 1'b1;
                        released_next = 1'b1;
                        fin_next      = s_final;
                        idx_next      = '0;
                        state_next    = ST_REL_RD;
                    end else if (s_final) begin
                        cmd.op    = DP_CLEAR;
                        seen_next = '0;
                    end else begin
                        cmd.ram_we = 1'b1;
                        seen_next  = seen_reg + CW'(1);
                    end
                end
            end
            ST_REL_RD: begin
                ram_addr = idx_reg[AW-1:0];
                if (idx_reg == seen_reg) begin
                    state_next = ST_REL_LAST;
                end else begin
                    cmd.ram_re = 1'b1;
                    state_next = ST_REL_FEED;
                end
            end
            ST_REL_FEED: begin
                if (sts.out_free) begin
                    cmd.op     = DP_FEED;
                    cmd.src    = SRC_RAM;
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_REL_RD;
                end
            end
            ST_REL_LAST: begin
                if (sts.out_free) begin
                    cmd.op  = DP_FEED;
                    cmd.src = SRC_HELD;
                    if (fin_reg) begin
                        pos_next   = 2'd1;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    if ({1'b0, pos_reg} >= fin_start) begin
                        cmd.op  = DP_FIN_POS;
                        cmd.pos = pos_reg;
                    end
                    if (pos_reg == 2'd3) begin
                        state_next = ST_FIN_EMIT;
                    end else begin
                        pos_next = pos_reg + 2'd1;
                    end
                end
            end
            ST_FIN_EMIT: begin
                if (sts.out_free) begin
                    cmd.op        = DP_FIN_EMIT;
                    released_next = 1'b0;
                    seen_next     = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            released_reg <= 1'b0;
            seen_reg     <= '0;
            idx_reg      <= '0;
            fin_reg      <= 1'b0;
            pos_reg      <= 2'd0;
        end else begin
            state_reg    <= state_next;
            released_reg <= released_next;
            seen_reg     <= seen_next;
            idx_reg      <= idx_next;
            fin_reg      <= fin_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

/* hdl/annexb_nal_unit_splitter_top.sv */
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_top
// Splits an H.264 Annex B byte stream into NAL unit bytes tagged with type
// and first/last markers.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one stream byte per transfer, final_byte set on the last one.
//   m_* channel: one NAL unit byte per transfer with its 5-bit type and
//   first/last flags. Bytes before the first start code are dropped.
//   cfg_wr_en/cfg_wr_data: write min_stream_length (reset 4) while idle.
// Timing:
//   The first bytes of a stream sit in the hold buffer until the count passes
//   min_stream_length (capped at HOLD_DEPTH). The byte that releases them
//   starts a burst that feeds each held byte and then itself, driven by the hold
//   buffer's single registered read port. After that one byte is taken per cycle
//   while the result register has room. A byte is tested once three more bytes
//   have entered the four-byte look-ahead window, and its result is loaded when
//   the next position tells whether it ends a unit, so a result trails its own
//   byte by at least four stream bytes. The final byte adds a flush of the window
//   that drains the untested tail. A short stream yields no transfers.
// Reset: clears all stream state; min_stream_length returns to 4.
// Stall: one result register; while m_ready is low and it is full, s_ready
//   drops and every datapath step holds; only a hold buffer read may go on.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_top
    import nalsplit_pkg::*;
#(
    parameter int unsigned HOLD_DEPTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int unsigned AW = $clog2(HOLD_DEPTH);

    logic [CFG_W-1:0] min_len_reg;
    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [AW-1:0]    ram_addr;

    // Threshold register; write it only while the block is idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= MIN_LEN_RESET;
        end else if (cfg_wr_en) begin
            min_len_reg <= cfg_wr_data;
        end
    end

    // Sequencer: decides per cycle which datapath step runs.
    nalsplit_ctrl #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .min_len  (min_len_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_final  (s_data.final_byte),
        .sts      (sts),
        .cmd      (cmd),
        .ram_addr (ram_addr)
    );

    // Window, matcher, pending byte and result register.
    nalsplit_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .ram_addr (ram_addr),
        .in_byte  (s_data.data_byte),
        .sts      (sts),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Any step that can produce a result only runs with room in the result register.
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_FEED || cmd.op == DP_FIN_POS || cmd.op == DP_FIN_EMIT)
        |-> sts.out_free)
        else $error("datapath step issued while result register full");

    // End-of-stream flush leaves an empty window for the next stream.
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_FIN_EMIT |=> sts.fill == 3'd0)
        else $error("window not cleared after stream end");

    // Window fill never exceeds its depth.
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.fill <= 3'(WIN_N))
        else $error("window fill count out of range");

    // Hold buffer is never written and read in the same cycle.
    a_ram_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ram_we |-> !cmd.ram_re && cmd.op == DP_NOP)
        else $error("hold buffer write overlaps another step");

endmodule

/* tb/nalsplit_checker.sv */
// ----------------------------------------------------------------------------
// nal_split_checker
// Watches both channels of the NAL unit splitter, predicts the unit bytes
// from every accepted stream byte, and compares each result transfer field by
// field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module nal_split_checker
    import nalsplit_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_item_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_item_t        m_data,
    output int               fail_count,
    output int               outstanding
);

    localparam int HOLD_N  = 32;
    localparam int HOLD_AW = $clog2(HOLD_N);
    localparam int RES_CAP = 40;

    // predictor state
    logic [CFG_W-1:0] min_len;
    logic [7:0]       win [WIN_N];
    int unsigned      win_fill;
    logic [7:0]       held [HOLD_N];
    logic [5:0]       seen_cnt;
    bit               in_unit;
    logic [4:0]       unit_type;
    logic [2:0]       skip_cnt;
    bit               released_q;
    bit               last_valid;
    logic [7:0]       last_byte;
    bit               last_first;
    int               step_results;

    out_item_t        nal_bytes_due [$];

    task automatic report(input string what);
        if (fail_count < 100)
            $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic void clear_stream();
        for (int i = 0; i < WIN_N; i++)
            win[i] = BYTE_ZERO;
        win_fill   = 0;
        seen_cnt   = '0;
        in_unit    = 1'b0;
        unit_type  = '0;
        skip_cnt   = '0;
        released_q = 1'b0;
        last_valid = 1'b0;
        last_byte  = '0;
        last_first = 1'b0;
    endfunction

    function automatic void flush_pending(input bit is_last);
        out_item_t item;
        if (!last_valid)
            return;
        if (step_results < RES_CAP) begin
            item.payload_byte = last_byte;
            item.nal_type     = unit_type;
            item.unit_first   = last_first;
            item.unit_last    = is_last;
            nal_bytes_due = {nal_bytes_due, item};
            step_results++;
        end
        last_valid = 1'b0;
    endfunction

    // One stream position with byte b; the window holds p .. p+3.
    function automatic void scan_position(input logic [7:0] b, input bit testable);
        logic [2:0] code_len;
        if (skip_cnt != 0) begin
            if (skip_cnt == 3'd1) begin
                in_unit    = 1'b1;
                unit_type  = b[4:0];
                last_valid = 1'b1;
                last_byte  = b;
                last_first = 1'b1;
            end
            skip_cnt = skip_cnt - 3'd1;
            return;
        end
        if (testable && win[0] == BYTE_ZERO && win[1] == BYTE_ZERO) begin
            code_len = 3'd0;
            if (win[2] == BYTE_ONE)
                code_len = 3'd3;
            else if (win[2] == BYTE_ZERO && win[3] == BYTE_ONE)
                code_len = 3'd4;
            if (code_len != 0) begin
                flush_pending(1'b1);
                skip_cnt = code_len;
                return;
            end
        end
        if (in_unit) begin
            flush_pending(1'b0);
            last_valid = 1'b1;
            last_byte  = b;
            last_first = 1'b0;
        end
    endfunction

    function automatic void shift_in(input logic [7:0] b);
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = b;
        if (win_fill < WIN_N)
            win_fill++;
        if (win_fill == WIN_N)
            scan_position(win[0], 1'b1);
    endfunction

    // Drain the untestable tail of the window at end of stream.
    function automatic void close_stream();
        int unsigned first_pos;
        first_pos = (win_fill >= WIN_N) ? 1 : WIN_N - win_fill;
        for (int unsigned i = first_pos; i < WIN_N; i++)
            scan_position(win[i], 1'b0);
        flush_pending(1'b1);
    endfunction

    function automatic void split_byte(input logic [7:0] b, input bit fin);
        int thr;
        step_results = 0;
        thr = (int'(min_len) > HOLD_N) ? HOLD_N : int'(min_len);
        if (!released_q) begin
            if (int'(seen_cnt) >= thr) begin
                released_q = 1'b1;
                for (int i = 0; i < int'(seen_cnt) && i < HOLD_N; i++)
                    shift_in(held[i]);
                shift_in(b);
            end else begin
                if (int'(seen_cnt) < HOLD_N)
                    held[seen_cnt[HOLD_AW-1:0]] = b;
                seen_cnt = seen_cnt + 6'd1;
            end
        end else begin
            shift_in(b);
        end
        if (fin) begin
            if (released_q)
                close_stream();
            clear_stream();
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            min_len = MIN_LEN_RESET;
            clear_stream();
            nal_bytes_due.delete();
        end else begin
            if (cfg_wr_en)
                min_len = cfg_wr_data;
            if (s_valid && s_ready)
                split_byte(s_data.data_byte, s_data.final_byte);
            if (m_valid && m_ready) begin
                if (nal_bytes_due.size() == 0) begin
                    report($sformatf("unexpected result transfer %h", m_data));
                end else begin
                    want = nal_bytes_due.pop_front();
                    if (m_data.payload_byte !== want.payload_byte)
                        report($sformatf("payload_byte got %h want %h",
                                         m_data.payload_byte, want.payload_byte));
                    if (m_data.nal_type !== want.nal_type)
                        report($sformatf("nal_type got %h want %h",
                                         m_data.nal_type, want.nal_type));
                    if (m_data.unit_first !== want.unit_first)
                        report($sformatf("unit_first got %b want %b",
                                         m_data.unit_first, want.unit_first));
                    if (m_data.unit_last !== want.unit_last)
                        report($sformatf("unit_last got %b want %b",
                                         m_data.unit_last, want.unit_last));
                end
            end
        end
        outstanding <= nal_bytes_due.size();
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Annex B NAL unit splitter: a directed set of
// streams for start code forms, short streams and stream-end cases, then
// random streams across several min_stream_length settings, with random
// gaps on both channels and one long result stall. A separate checker
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module testbench;
    import nalsplit_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int HOLD_DEPTH    = 32;
    // release burst over every held byte, the window flush, margin
    localparam int DRAIN_CYCLES  = 2 * HOLD_DEPTH + 2 + 4 + 20;
    localparam int RANDOM_ITEMS  = 100;
    localparam int HOLD_OFF_AFTER  = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 200000;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_item_t         s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_item_t        m_data;

    int               fail_count;
    int               outstanding;
    int               cycle_count = 0;

    bit               tx_calm = 1'b0;
    bit               rx_calm = 1'b0;
    bit               held_off = 1'b0;
    logic [7:0]       stream_q [$];

    always #(HALF_PERIOD) aclk = ~aclk;

    annexb_nal_unit_splitter_top #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    nal_split_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Offer one stream byte and hold it until the transfer completes.
    // Lower valid only when a gap is drawn, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b, input bit fin);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {b, fin};    // packed order: data_byte, final_byte
        do @(posedge aclk); while (!s_ready);
    endtask

    // Send the queued stream, flagging its last byte as final.
    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    // Drop valid, wait for every predicted byte, then let the block finish
    // any release burst or flush that yields nothing.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write min_stream_length; call only while idle.
    task automatic write_min_len(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Build a stream of len bytes. Well-formed streams open with a start code
    // (after a little junk) and carry more start codes at random; noisy ones
    // are raw bytes heavy in 00 and 01. Truncation may cut a start code short.
    task automatic make_stream(input int len, input bit noisy);
        bit need_code;
        int pick;
        stream_q.delete();
        need_code = !noisy;
        if (!noisy)
            repeat ($urandom_range(0, 2)) stream_q = {stream_q, 8'($urandom_range(1, 255))};
        while (stream_q.size() < len) begin
            if (need_code || (!noisy && $urandom_range(0, 11) == 0)) begin
                need_code = 1'b0;
                stream_q = {stream_q, BYTE_ZERO, BYTE_ZERO};
                if ($urandom_range(0, 1) == 1)
                    stream_q = {stream_q, BYTE_ZERO};
                stream_q = {stream_q, BYTE_ONE, 8'($urandom)};
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < (noisy ? 4 : 2))
                    stream_q = {stream_q, BYTE_ZERO};
                else if (pick < (noisy ? 6 : 3))
                    stream_q = {stream_q, BYTE_ONE};
                else
                    stream_q = {stream_q, 8'($urandom)};
            end
        end
        while (stream_q.size() > len)
            void'(stream_q.pop_back());
    endtask

    // Result side: random ready gaps, once a long hold-off so the single
    // result register fills and the input stalls while bytes keep coming.
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held_off && taken >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                gap = HOLD_OFF_CYCLES;
            end else begin
                gap = rx_calm ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    // Cycle counter: end a hung run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int         sent;
        int         phase;
        int         thr;
        int         eff;
        int         len;
        int         r;
        int         n_streams;
        logic [7:0] mixed [$];

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset threshold of 4.
        // Short stream: everything held is discarded.
        stream_q = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE};
        send_stream();
        // Junk before the first start code, a header with every type bit set,
        // a 00 payload byte ahead of a 4-byte code, a 3-byte code, and a
        // start code ending exactly at stream end.
        mixed = '{8'hAB, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h01, 8'h41, 8'h80, 8'h00, 8'h00, 8'h01};
        stream_q = mixed;
        send_stream();
        wait_idle();

        // Threshold 0: a one-byte stream, then a one-byte unit whose header
        // is the final byte.
        write_min_len(CFG_W'(0));
        stream_q = '{BYTE_ZERO};
        send_stream();
        stream_q = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE, 8'h09};
        send_stream();

        // Random streams, cycling through thresholds including the extremes
        // and one above the hold depth.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            case (phase % 8)
                0:       thr = 0;
                1:       thr = 32;
                2:       thr = 2;
                3:       thr = 63;
                4:       thr = $urandom_range(3, 8);
                5:       thr = 1;
                6:       thr = $urandom_range(0, 12);
                default: thr = 4;
            endcase
            write_min_len(CFG_W'(thr));
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            eff = (thr > HOLD_DEPTH) ? HOLD_DEPTH : thr;
            n_streams = (eff >= 16) ? 1 : 3;
            repeat (n_streams) begin
                r = $urandom_range(0, 5);
                if (r == 0 && eff > 0)
                    len = $urandom_range(1, eff);   // at or below threshold
                else if (r == 1)
                    len = eff + 1;                  // released by its final byte
                else
                    len = eff + $urandom_range(2, 10);
                make_stream(len, $urandom_range(0, 4) == 0);
                send_stream();
                sent += len;
            end
            phase++;
        end

        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/nalsplit_pkg.sv
hdl/nalsplit_ram.sv
hdl/nalsplit_dp.sv
hdl/nalsplit_ctrl.sv
hdl/annexb_nal_unit_splitter_top.sv
tb/nalsplit_checker.sv
tb/testbench.sv
